// ===== design/tcl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcl_pkg: shared types and constants of the token classifier
// Character classes, token kinds, keyword table and the queue entry format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcl_pkg;

	localparam int KW_CHARS  = 8;
	localparam int KW_IDX_W  = $clog2(KW_CHARS);
	localparam int KW_LEN_W  = $clog2(KW_CHARS + 1);
	localparam int NUM_KW    = 23;
	localparam int CNT_BITS  = 16;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		KIND_OP      = 3'd0,
		KIND_SPECIAL = 3'd1,
		KIND_KEYWORD = 3'd2,
		KIND_INT     = 3'd3,
		KIND_REAL    = 3'd4,
		KIND_IDENT   = 3'd5,
		KIND_BAD_ID  = 3'd6
	} kind_t;

	// keyword text, right-justified: last character in the lowest byte
	localparam logic [NUM_KW-1:0][KW_CHARS*8-1:0] KW_TEXT = {
		(KW_CHARS*8)'("goto"),     (KW_CHARS*8)'("struct"),  (KW_CHARS*8)'("static"),
		(KW_CHARS*8)'("void"),     (KW_CHARS*8)'("unsigned"),(KW_CHARS*8)'("switch"),
		(KW_CHARS*8)'("typedef"),  (KW_CHARS*8)'("short"),   (KW_CHARS*8)'("long"),
		(KW_CHARS*8)'("sizeof"),   (KW_CHARS*8)'("case"),    (KW_CHARS*8)'("char"),
		(KW_CHARS*8)'("return"),   (KW_CHARS*8)'("float"),   (KW_CHARS*8)'("double"),
		(KW_CHARS*8)'("int"),      (KW_CHARS*8)'("continue"),(KW_CHARS*8)'("main"),
		(KW_CHARS*8)'("break"),    (KW_CHARS*8)'("do"),      (KW_CHARS*8)'("while"),
		(KW_CHARS*8)'("else"),     (KW_CHARS*8)'("if")
	};

	localparam logic [NUM_KW-1:0][KW_LEN_W-1:0] KW_LEN = {
		KW_LEN_W'(4), KW_LEN_W'(6), KW_LEN_W'(6), KW_LEN_W'(4), KW_LEN_W'(8),
		KW_LEN_W'(6), KW_LEN_W'(7), KW_LEN_W'(5), KW_LEN_W'(4), KW_LEN_W'(6),
		KW_LEN_W'(4), KW_LEN_W'(4), KW_LEN_W'(6), KW_LEN_W'(5), KW_LEN_W'(6),
		KW_LEN_W'(3), KW_LEN_W'(8), KW_LEN_W'(4), KW_LEN_W'(5), KW_LEN_W'(2),
		KW_LEN_W'(5), KW_LEN_W'(4), KW_LEN_W'(2)
	};

	// one queue entry: everything one input character produces
	typedef struct packed {
		logic        w_vld;
		kind_t       w_kind;
		logic [15:0] w_start;
		logic [15:0] w_len;
		logic        s_vld;
		kind_t       s_kind;
		logic [7:0]  s_char;
		logic [15:0] s_start;
	} tok_entry_t;

	function automatic logic is_delim(input logic [7:0] c);
		return c == 8'h20 || c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
			c == 8'h2C || c == 8'h3B || c == 8'h3E || c == 8'h3C || c == 8'h3D ||
			c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h7B ||
			c == 8'h7D;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
			c == 8'h3E || c == 8'h3C || c == 8'h3D;
	endfunction

endpackage

// ===== design/token_classifier_lexer_top.sv =====
// ----------------------------------------------------------------------------
// token_classifier_lexer_top: streaming lexical tokenizer
// Splits a character stream into tokens and classifies each one.
//
//   group  dir  tdata (low bit up)                        tuser       tlast
//   s_*    in   char_code[7:0]                            -           end_of_string
//   m_*    out  token_number, token_start, token_length,  token_kind  last_of_run
//                symbol_char
//
// One character is accepted per cycle while the four-entry queue has room.
// Each result is one output transfer; a delimiter other than a space that closes
// a word gives two results, its word token first and then its symbol token.
// Reset is asynchronous and clears word state, string position and token count.
// A stalled output fills the queue, after which s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_classifier_lexer_top import tcl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // number[15:0] start[31:16] len[47:32] sym[55:48]
	output logic [2:0]  m_tuser,   // token_kind[2:0]
	output logic        m_tlast
);

	logic       push, full, pop, empty;
	tok_entry_t push_data, head;

	logic [15:0] token_number, token_start, token_length;
	logic [7:0]  symbol_char;

	tcl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (s_tvalid),
		.in_rdy        (s_tready),
		.char_code     (s_tdata),
		.end_of_string (s_tlast),
		.push          (push),
		.push_data     (push_data),
		.q_full        (full)
	);

	tcl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	tcl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_vld      (m_tvalid),
		.out_rdy      (m_tready),
		.token_kind   (m_tuser),
		.token_number (token_number),
		.token_start  (token_start),
		.token_length (token_length),
		.symbol_char  (symbol_char),
		.last_of_run  (m_tlast)
	);

	assign m_tdata = {symbol_char, token_length, token_start, token_number};

endmodule

// ===== design/tcl_front.sv =====
// ----------------------------------------------------------------------------
// tcl_front: character intake and word classification
// Tracks the open word, classifies it when it closes and queues one entry
// per character that yields tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcl_front import tcl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	output logic        in_rdy,
	input  logic [7:0]  char_code,
	input  logic        end_of_string,
	output logic        push,
	output tok_entry_t  push_data,
	input  logic        q_full
);

	logic [15:0] pos_q, start_q, wlen_q;
	logic        ad_q, dd_q, sd_q, fd_q;
	logic [KW_CHARS-1:0][7:0] kbuf_q;

	logic        acc, delim, dig, dot, open, close, kw;
	logic [15:0] start_n, len_n;
	logic        ad_n, dd_n, sd_n, fd_n;
	logic        kb_we;
	logic [KW_CHARS-1:0][7:0] kbuf_n;
	kind_t       wkind;

	function automatic logic kw_hit(input logic [KW_CHARS-1:0][7:0] b,
			input logic [15:0] len);
		logic hit;
		logic m;
		hit = 1'b0;
		for (int k = 0; k < NUM_KW; k++) begin
			m = (len == 16'(KW_LEN[k]));
			for (int i = 0; i < KW_CHARS; i++) begin
				if (i < int'(KW_LEN[k]))
					m = m & (b[i] == KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8]);
			end
			hit = hit | m;
		end
		return hit;
	endfunction

	assign in_rdy = !q_full;
	assign acc    = in_vld && in_rdy;
	assign delim  = is_delim(char_code);
	assign dig    = char_code >= 8'h30 && char_code <= 8'h39;
	assign dot    = char_code == 8'h2E;
	assign open   = wlen_q != 16'd0;
	assign kb_we  = !delim && wlen_q < 16'(KW_CHARS);

	always_comb begin
		start_n = start_q;
		len_n   = wlen_q;
		ad_n    = ad_q;
		dd_n    = dd_q;
		sd_n    = sd_q;
		fd_n    = fd_q;
		kbuf_n  = kbuf_q;
		if (!delim) begin
			if (!open) begin
				start_n = pos_q;
				fd_n    = dig;
			end
			ad_n  = (open ? ad_q : 1'b1) & dig;
			dd_n  = (open ? dd_q : 1'b1) & (dig | dot);
			sd_n  = (open ? sd_q : 1'b0) | dot;
			len_n = (wlen_q == 16'hFFFF) ? wlen_q : wlen_q + 16'd1;
			if (kb_we)
				kbuf_n[wlen_q[KW_IDX_W-1:0]] = char_code;
		end
	end

	assign close = (delim || end_of_string) && len_n != 16'd0;
	assign kw    = len_n <= 16'(KW_CHARS) && kw_hit(kbuf_n, len_n);

	always_comb begin
		priority if (kw)           wkind = KIND_KEYWORD;
		else if (ad_n)             wkind = KIND_INT;
		else if (dd_n && sd_n)     wkind = KIND_REAL;
		else if (fd_n)             wkind = KIND_BAD_ID;
		else                       wkind = KIND_IDENT;
	end

	always_comb begin
		push_data.w_vld   = close;
		push_data.w_kind  = wkind;
		push_data.w_start = start_n;
		push_data.w_len   = len_n;
		push_data.s_vld   = delim && char_code != 8'h20;
		push_data.s_kind  = is_op(char_code) ? KIND_OP : KIND_SPECIAL;
		push_data.s_char  = char_code;
		push_data.s_start = pos_q;
	end

	assign push = acc && (push_data.w_vld || push_data.s_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			wlen_q  <= '0;
			ad_q    <= 1'b1;
			dd_q    <= 1'b1;
			sd_q    <= 1'b0;
			fd_q    <= 1'b0;
		end else if (acc) begin
			pos_q   <= end_of_string ? 16'd0 : pos_q + 16'd1;
			start_q <= start_n;
			if (close || end_of_string) begin
				wlen_q <= '0;
				ad_q   <= 1'b1;
				dd_q   <= 1'b1;
				sd_q   <= 1'b0;
				fd_q   <= 1'b0;
			end else begin
				wlen_q <= len_n;
				ad_q   <= ad_n;
				dd_q   <= dd_n;
				sd_q   <= sd_n;
				fd_q   <= fd_n;
			end
		end
	end

	// keyword buffer: no reset, only entries of the open word are read
	always_ff @(posedge clk) begin
		if (acc && kb_we)
			kbuf_q[wlen_q[KW_IDX_W-1:0]] <= char_code;
	end

endmodule

// ===== design/tcl_queue.sv =====
// ----------------------------------------------------------------------------
// tcl_queue: short entry queue between front and back
// Register-based first-in first-out buffer; the head entry is read combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcl_queue import tcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tok_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output tok_entry_t head,
	output logic       empty
);

	tok_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (QPTR_W + 1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue read while empty");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W + 1)'(QDEPTH)) else $error("queue count out of range");

endmodule

// ===== design/tcl_back.sv =====
// ----------------------------------------------------------------------------
// tcl_back: token emission
// Splits each queue entry into its word and symbol tokens, numbers them and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcl_back import tcl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tok_entry_t  head,
	input  logic        empty,
	output logic        pop,
	output logic        out_vld,
	input  logic        out_rdy,
	output logic [2:0]  token_kind,
	output logic [15:0] token_number,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [7:0]  symbol_char,
	output logic        last_of_run
);

	logic                ov_q, phase_q, last_q;
	logic [CNT_BITS-1:0] cnt_q;
	kind_t               kind_q;
	logic [15:0]         start_q, len_q;
	logic [7:0]          sym_q;

	logic load, do_word, last_part;
	logic [CNT_BITS-1:0] cnt_n;

	assign load      = (!ov_q || out_rdy) && !empty;
	// word part goes first when the entry has one and it is not yet sent
	assign do_word   = head.w_vld && !phase_q;
	assign last_part = !do_word || !head.s_vld;
	assign pop       = load && last_part;
	assign cnt_n     = cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				ov_q    <= 1'b1;
				cnt_q   <= cnt_n;
				phase_q <= !last_part;
			end else if (out_rdy) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= last_part;
			if (do_word) begin
				kind_q  <= head.w_kind;
				start_q <= head.w_start;
				len_q   <= head.w_len;
				sym_q   <= 8'd0;
			end else begin
				kind_q  <= head.s_kind;
				start_q <= head.s_start;
				len_q   <= 16'd1;
				sym_q   <= head.s_char;
			end
		end
	end

	// token number is the counter after this token
	logic [CNT_BITS-1:0] num_q;
	always_ff @(posedge clk) begin
		if (load)
			num_q <= cnt_n;
	end

	assign out_vld      = ov_q;
	assign token_kind   = kind_q;
	assign token_number = 16'(num_q);
	assign token_start  = start_q;
	assign token_length = len_q;
	assign symbol_char  = sym_q;
	assign last_of_run  = last_q;

	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !empty && head.s_vld) else $error("second part without entry");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> cnt_q == $past(cnt_n)) else $error("token counter skipped");
	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> head.w_vld || head.s_vld) else $error("queue entry holds no token");

endmodule
